// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/izrs_pkg.sv =====
// Types, codes and constants of the irrigation zone run sequencer.
`timescale 1ns / 1ps

package izrs_pkg;

    // Field widths.
    localparam int unsigned ZONE_W  = 4;
    localparam int unsigned TIME_W  = 24;
    localparam int unsigned PHASE_W = 16;
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned RUN_W   = 3;
    localparam int unsigned CIDX_W  = 2;

    // Highest zone that has a valve.
    localparam int unsigned NUM_ZONES = 8;

    // Reset values of the timing registers.
    localparam logic [PHASE_W-1:0] PREOPEN_RESET = 16'd2000;
    localparam logic [PHASE_W-1:0] RELIEF_RESET  = 16'd2000;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_PREOPEN = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_RELIEF  = 2'd1;

    // Request types.
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK   = 2'd0,
        REQ_START  = 2'd1,
        REQ_CANCEL = 2'd2
    } req_t;

    // Reported run state codes.
    typedef enum logic [RUN_W-1:0] {
        RUN_IDLE      = 3'd0,
        RUN_PREOPEN   = 3'd1,
        RUN_RUNNING   = 3'd2,
        RUN_STOPDELAY = 3'd3,
        RUN_COMPLETE  = 3'd4,
        RUN_FAULT     = 3'd5
    } run_code_t;

    // Status codes.
    typedef enum logic [CODE_W-1:0] {
        CODE_NONE        = 4'd0,
        CODE_SELECT_AREA = 4'd1,
        CODE_SELECT_TIME = 4'd2,
        CODE_ZONE_ERROR  = 4'd3,
        CODE_OPENING     = 4'd4,
        CODE_WATERING    = 4'd5,
        CODE_DEPRESS     = 4'd6,
        CODE_COMPLETE    = 4'd7,
        CODE_CANCELLED   = 4'd8
    } status_t;

    // Sequencer state, one-hot.
    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_PREOPEN   = 6'b000010,
        S_RUNNING   = 6'b000100,
        S_STOPDELAY = 6'b001000,
        S_COMPLETE  = 6'b010000,
        S_FAULT     = 6'b100000
    } seq_state_t;

    // One result item.
    typedef struct packed {
        run_code_t          run_state;
        logic               pump_on;
        logic [ZONE_W-1:0]  active_zone;
        logic [TIME_W-1:0]  remaining_ms;
        status_t            status_code;
        logic               start_ok;
    } result_t;

    // Map the one-hot state to its reported code.
    function automatic run_code_t state_code(input seq_state_t s);
        run_code_t c;
        case (s)
            S_IDLE:      c = RUN_IDLE;
            S_PREOPEN:   c = RUN_PREOPEN;
            S_RUNNING:   c = RUN_RUNNING;
            S_STOPDELAY: c = RUN_STOPDELAY;
            S_COMPLETE:  c = RUN_COMPLETE;
            S_FAULT:     c = RUN_FAULT;
            default:     c = RUN_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/izrs_core.sv =====
// Sequencer state and the next-state logic for one request.
`timescale 1ns / 1ps

module izrs_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [izrs_pkg::REQ_W-1:0]        req_type,
    input  logic [izrs_pkg::ZONE_W-1:0]       zone,
    input  logic [izrs_pkg::TIME_W-1:0]       duration_ms,
    input  logic [izrs_pkg::PHASE_W-1:0]      preopen_ms,
    input  logic [izrs_pkg::PHASE_W-1:0]      relief_ms,
    output izrs_pkg::result_t                 result
);

    izrs_pkg::seq_state_t               state_reg, state_next;
    logic                               cycle_active_reg, cycle_active_next;
    logic                               pump_drive_reg, pump_drive_next;
    logic [izrs_pkg::ZONE_W-1:0]        open_zone_reg, open_zone_next;
    logic [izrs_pkg::TIME_W-1:0]        run_length_reg, run_length_next;
    logic [izrs_pkg::TIME_W-1:0]        time_left_reg, time_left_next;
    logic [izrs_pkg::PHASE_W-1:0]       phase_count_reg, phase_count_next;
    izrs_pkg::status_t                  last_code_reg, last_code_next;
    logic                               start_ok;
    logic [izrs_pkg::PHASE_W-1:0]       phase_dec;
    logic [izrs_pkg::TIME_W-1:0]        time_dec;

    // Saturating countdowns of the phase wait and the watering time.
    assign phase_dec = (phase_count_reg == '0) ? '0 : phase_count_reg - 1'b1;
    assign time_dec  = (time_left_reg == '0) ? '0 : time_left_reg - 1'b1;

    // Next state for the request that is processed this cycle.
    always_comb
    begin
        state_next        = state_reg;
        cycle_active_next = cycle_active_reg;
        pump_drive_next   = pump_drive_reg;
        open_zone_next    = open_zone_reg;
        run_length_next   = run_length_reg;
        time_left_next    = time_left_reg;
        phase_count_next  = phase_count_reg;
        last_code_next    = last_code_reg;
        start_ok          = 1'b0;
        case (req_type)
            izrs_pkg::REQ_TICK:
            begin
                if (cycle_active_reg)
                begin
                    case (state_reg)
                        izrs_pkg::S_PREOPEN:
                        begin
                            phase_count_next = phase_dec;
                            if (phase_dec == '0)
                            begin
                                pump_drive_next = 1'b1;
                                time_left_next  = run_length_reg;
                                state_next      = izrs_pkg::S_RUNNING;
                                last_code_next  = izrs_pkg::CODE_WATERING;
                            end
                        end
                        izrs_pkg::S_RUNNING:
                        begin
                            time_left_next = time_dec;
                            if (time_dec == '0)
                            begin
                                pump_drive_next  = 1'b0;
                                state_next       = izrs_pkg::S_STOPDELAY;
                                last_code_next   = izrs_pkg::CODE_DEPRESS;
                                phase_count_next = relief_ms;
                            end
                        end
                        izrs_pkg::S_STOPDELAY:
                        begin
                            phase_count_next = phase_dec;
                            if (phase_dec == '0)
                            begin
                                cycle_active_next = 1'b0;
                                pump_drive_next   = 1'b0;
                                open_zone_next    = '0;
                                time_left_next    = '0;
                                phase_count_next  = '0;
                                state_next        = izrs_pkg::S_COMPLETE;
                                last_code_next    = izrs_pkg::CODE_COMPLETE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            izrs_pkg::REQ_START:
            begin
                if (zone == '0)
                begin
                    last_code_next = izrs_pkg::CODE_SELECT_AREA;
                end
                else if (duration_ms == '0)
                begin
                    last_code_next = izrs_pkg::CODE_SELECT_TIME;
                end
                else
                begin
                    // Any accepted or faulting start first stops what runs.
                    cycle_active_next = 1'b0;
                    pump_drive_next   = 1'b0;
                    open_zone_next    = '0;
                    time_left_next    = '0;
                    phase_count_next  = '0;
                    if (zone > izrs_pkg::ZONE_W'(izrs_pkg::NUM_ZONES))
                    begin
                        state_next     = izrs_pkg::S_FAULT;
                        last_code_next = izrs_pkg::CODE_ZONE_ERROR;
                    end
                    else
                    begin
                        open_zone_next    = zone;
                        run_length_next   = duration_ms;
                        time_left_next    = duration_ms;
                        cycle_active_next = 1'b1;
                        state_next        = izrs_pkg::S_PREOPEN;
                        last_code_next    = izrs_pkg::CODE_OPENING;
                        phase_count_next  = preopen_ms;
                        start_ok          = 1'b1;
                    end
                end
            end
            izrs_pkg::REQ_CANCEL:
            begin
                cycle_active_next = 1'b0;
                pump_drive_next   = 1'b0;
                open_zone_next    = '0;
                time_left_next    = '0;
                phase_count_next  = '0;
                state_next        = izrs_pkg::S_IDLE;
                last_code_next    = izrs_pkg::CODE_CANCELLED;
            end
            default:
            begin
            end
        endcase
    end

    // The result reports the state after this request.
    always_comb
    begin
        result.run_state    = izrs_pkg::state_code(state_next);
        result.pump_on      = pump_drive_next;
        result.active_zone  = open_zone_next;
        result.remaining_ms = time_left_next;
        result.status_code  = last_code_next;
        result.start_ok     = start_ok;
    end

    // State registers advance once per processed request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= izrs_pkg::S_IDLE;
            cycle_active_reg <= 1'b0;
            pump_drive_reg   <= 1'b0;
            open_zone_reg    <= '0;
            run_length_reg   <= '0;
            time_left_reg    <= '0;
            phase_count_reg  <= '0;
            last_code_reg    <= izrs_pkg::CODE_NONE;
        end
        else if (step)
        begin
            state_reg        <= state_next;
            cycle_active_reg <= cycle_active_next;
            pump_drive_reg   <= pump_drive_next;
            open_zone_reg    <= open_zone_next;
            run_length_reg   <= run_length_next;
            time_left_reg    <= time_left_next;
            phase_count_reg  <= phase_count_next;
            last_code_reg    <= last_code_next;
        end
    end

endmodule

// ===== sv/irrigation_zone_run_sequencer.sv =====
// Irrigation zone run sequencer: input register, sequencer core, result register.
// Each request (tick, start or cancel) yields one result, held first in the input
// register and then in the result register. A new request can be taken every cycle
// unless out_ready low holds the result register, since the whole state update is a
// single short step of the sequencer core between those two registers. The timing
// registers preopen_ms and relief_ms are written through the configuration
// channel, which is always ready; write them only while no request is in flight.
`timescale 1ns / 1ps

module irrigation_zone_run_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel.
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [izrs_pkg::REQ_W-1:0]        req_type,
    input  logic [izrs_pkg::ZONE_W-1:0]       zone,
    input  logic [izrs_pkg::TIME_W-1:0]       duration_ms,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [izrs_pkg::RUN_W-1:0]        run_state,
    output logic                              pump_on,
    output logic [izrs_pkg::ZONE_W-1:0]       active_zone,
    output logic [izrs_pkg::TIME_W-1:0]       remaining_ms,
    output logic [izrs_pkg::CODE_W-1:0]       status_code,
    output logic                              start_ok,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [izrs_pkg::CIDX_W-1:0]       cfg_index,
    input  logic [izrs_pkg::PHASE_W-1:0]      cfg_data
);

    logic                               stg_valid_reg;
    logic [izrs_pkg::REQ_W-1:0]         stg_req_reg;
    logic [izrs_pkg::ZONE_W-1:0]        stg_zone_reg;
    logic [izrs_pkg::TIME_W-1:0]        stg_dur_reg;
    logic                               out_valid_reg;
    izrs_pkg::result_t                  out_reg;
    izrs_pkg::result_t                  core_result;
    logic [izrs_pkg::PHASE_W-1:0]       preopen_reg;
    logic [izrs_pkg::PHASE_W-1:0]       relief_reg;
    logic                               advance;
    logic                               in_xfer;

    // The staged request moves on when the result register is free or drains.
    assign advance   = stg_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stg_valid_reg || advance;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preopen_reg <= izrs_pkg::PREOPEN_RESET;
            relief_reg  <= izrs_pkg::RELIEF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                izrs_pkg::CFG_PREOPEN: preopen_reg <= cfg_data;
                izrs_pkg::CFG_RELIEF:  relief_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_xfer)
            stg_valid_reg <= 1'b1;
        else if (advance)
            stg_valid_reg <= 1'b0;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stg_req_reg  <= req_type;
            stg_zone_reg <= zone;
            stg_dur_reg  <= duration_ms;
        end
    end

    izrs_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .req_type    (stg_req_reg),
        .zone        (stg_zone_reg),
        .duration_ms (stg_dur_reg),
        .preopen_ms  (preopen_reg),
        .relief_ms   (relief_reg),
        .result      (core_result)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= core_result;
    end

    assign out_valid    = out_valid_reg;
    assign run_state    = out_reg.run_state;
    assign pump_on      = out_reg.pump_on;
    assign active_zone  = out_reg.active_zone;
    assign remaining_ms = out_reg.remaining_ms;
    assign status_code  = out_reg.status_code;
    assign start_ok     = out_reg.start_ok;

endmodule

// ===== sv/izrs_checker.sv =====
// Port-level checker for the irrigation zone run sequencer, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module izrs_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [izrs_pkg::RUN_W-1:0]        run_state,
    input logic                              pump_on,
    input logic [izrs_pkg::ZONE_W-1:0]       active_zone,
    input logic [izrs_pkg::TIME_W-1:0]       remaining_ms,
    input logic [izrs_pkg::CODE_W-1:0]       status_code,
    input logic                              start_ok
);

    // The pump only runs in the running state.
    `ASSERT_SAME(a_pump_only_running, clk, rst_n, out_valid && pump_on,
        run_state == izrs_pkg::RUN_RUNNING)

    // Idle, complete and fault leave the valve closed and nothing to go.
    `ASSERT_SAME(a_rest_is_clear, clk, rst_n,
        out_valid && (run_state == izrs_pkg::RUN_IDLE ||
                      run_state == izrs_pkg::RUN_COMPLETE ||
                      run_state == izrs_pkg::RUN_FAULT),
        !pump_on && active_zone == '0 && remaining_ms == '0)

    // An accepted start always opens a valid zone in preopen.
    `ASSERT_SAME(a_start_opens, clk, rst_n, out_valid && start_ok,
        run_state == izrs_pkg::RUN_PREOPEN && status_code == izrs_pkg::CODE_OPENING &&
        active_zone != '0 && remaining_ms != '0)

    // A result that is not taken stays offered.
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind irrigation_zone_run_sequencer izrs_checker u_izrs_checker (.*);
